[sv/pwt_pkg.sv]
// Shared constants for the pending work tracker.
// No dependencies; imported by pwt_ram, pending_work_tracker and the bench.
`default_nettype none

package pwt_pkg;

    localparam int unsigned PWT_DEPTH  = 16;
    localparam int unsigned PWT_WORD_W = 32;

endpackage

`default_nettype wire

[sv/pending_work_tracker.sv]
// Pending work tracker: ring FIFO of issued numbers with delete by value.
// A nonzero word walks the N queued entries, one entry per cycle through the
// RAM read port; a zero word or an empty ring skips the walk. Not ready while
// a word is in work. Reset (synchronous, active low): ring empty, head 0,
// issue counter 1. Ring contents are not cleared; only written entries are
// ever read.
`default_nettype none

module pending_work_tracker
    import pwt_pkg::*;
#(
    parameter int unsigned RING_DEPTH = PWT_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] completed_value
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [71:0] o_m_tdata    // [31:0] issued_number, [32] was_queued,
                                          // [64:33] confirmed_below, [71:65] zero
);

    localparam int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);
    localparam int unsigned SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(RING_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
    localparam logic [IW-1:0] LAST_IX = IW'(RING_DEPTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_ENQ  = 3'd2;
    localparam logic [2:0] S_HEAD = 3'd3;
    localparam logic [2:0] S_RES  = 3'd4;

    logic [2:0]            r_state,   n_state;
    logic [IW-1:0]         r_head,    n_head;
    logic [CW-1:0]         r_count,   n_count;
    logic [31:0]           r_issue,   n_issue;
    logic [31:0]           r_target,  n_target;
    logic [CW-1:0]         r_rd_left, n_rd_left;
    logic [IW-1:0]         r_rd_addr, n_rd_addr;
    logic                  r_cmp_vld, n_cmp_vld;
    logic                  r_queued,  n_queued;
    logic                  r_m_valid, n_m_valid;
    logic [71:0]           r_m_data,  n_m_data;

    logic [SW-1:0]         tail_sum;
    logic [IW-1:0]         tail_ix;
    logic [IW-1:0]         head_inc;
    logic [IW-1:0]         rd_addr_inc;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [PWT_WORD_W-1:0] wr_data;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic [PWT_WORD_W-1:0] rd_data;

    // shared slot adder: (head + count) mod depth
    always_comb begin
        tail_sum = SW'(r_head) + SW'(r_count);
        if (tail_sum >= DEPTH_S) begin
            tail_sum = tail_sum - DEPTH_S;
        end
        tail_ix = tail_sum[IW-1:0];
    end

    assign head_inc    = (r_head == LAST_IX) ? '0 : r_head + 1'b1;
    assign rd_addr_inc = (r_rd_addr == LAST_IX) ? '0 : r_rd_addr + 1'b1;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    pwt_ram #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_issue   = r_issue;
        n_target  = r_target;
        n_rd_left = r_rd_left;
        n_rd_addr = r_rd_addr;
        n_cmp_vld = 1'b0;
        n_queued  = r_queued;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        wr_en     = 1'b0;
        wr_addr   = tail_ix;
        wr_data   = rd_data;
        rd_en     = 1'b0;
        rd_addr   = r_rd_addr;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_target  = i_s_tdata;
                    n_rd_left = r_count;
                    n_rd_addr = r_head;
                    if (i_s_tdata != 32'd0 && r_count != '0) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_ENQ;
                    end
                end
            end
            S_WALK: begin
                // reads run one slot ahead of the compare
                if (r_rd_left != '0) begin
                    rd_en     = 1'b1;
                    n_rd_addr = rd_addr_inc;
                    n_rd_left = r_rd_left - 1'b1;
                    n_cmp_vld = 1'b1;
                end else begin
                    n_state = S_ENQ;
                end
                if (r_cmp_vld) begin
                    n_head = head_inc;
                    if (rd_data == r_target) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        wr_en = 1'b1;
                    end
                end
            end
            S_ENQ: begin
                n_issue = r_issue + 32'd1;
                wr_data = n_issue;
                if (r_count < DEPTH_C) begin
                    wr_en    = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_queued = 1'b1;
                end else begin
                    n_queued = 1'b0;
                end
                n_state = S_HEAD;
            end
            S_HEAD: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
                n_state = S_RES;
            end
            S_RES: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {7'd0, rd_data - 32'd1, r_queued, r_issue};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_issue   <= 32'd1;
            r_rd_left <= '0;
            r_cmp_vld <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_issue   <= n_issue;
            r_rd_left <= n_rd_left;
            r_cmp_vld <= n_cmp_vld;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target  <= n_target;
        r_rd_addr <= n_rd_addr;
        r_queued  <= n_queued;
        r_m_data  <= n_m_data;
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above ring depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready right after accepting a word");

    a_walk_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("walk writes the slot being read");

    a_res_from_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES) |-> (r_count != '0))
        else $error("result taken from an empty ring");
`endif

endmodule

`default_nettype wire

[sv/pwt_ram.sv]
// Ring storage for the pending work tracker: one write, one registered read.
// Depends on pwt_pkg.
`default_nettype none

module pwt_ram
    import pwt_pkg::*;
#(
    parameter int unsigned DEPTH  = PWT_DEPTH,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_wr_en,
    input  wire logic [ADDR_W-1:0]     i_wr_addr,
    input  wire logic [PWT_WORD_W-1:0] i_wr_data,
    input  wire logic                  i_rd_en,
    input  wire logic [ADDR_W-1:0]     i_rd_addr,
    output logic      [PWT_WORD_W-1:0] o_rd_data
);

    logic [PWT_WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[tb/pending_work_tracker_tb.sv]
// Self-checking bench for pending_work_tracker: a scoreboard class predicts each
// result word from the accepted input words; a task drives the input side and an initial block the result side.
// Depends on pwt_pkg and pending_work_tracker.
`default_nettype none

module pending_work_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pwt_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_WORDS = 530;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_OFF     = 300;

    typedef struct packed {
        logic [6:0]  pad;
        logic [31:0] confirmed_below;
        logic        was_queued;
        logic [31:0] issued_number;
    } t_tracker_result;

    class pending_scoreboard;
        logic [31:0]     pending_q[$];
        logic [31:0]     issue_count;
        t_tracker_result result_q[$];
        int              words_in;
        int              errors;

        function new();
            issue_count = 32'd1;
            words_in    = 0;
            errors      = 0;
        endfunction

        function void note_word(logic [31:0] done);
            t_tracker_result r;
            words_in++;
            if (done != 32'd0) begin
                for (int i = pending_q.size() - 1; i >= 0; i--) begin
                    if (pending_q[i] == done) pending_q.delete(i);
                end
            end
            issue_count = issue_count + 32'd1;
            r.pad           = '0;
            r.issued_number = issue_count;
            r.was_queued    = pending_q.size() < PWT_DEPTH;
            if (r.was_queued) pending_q.push_back(issue_count);
            r.confirmed_below = pending_q[0] - 32'd1;
            result_q.push_back(r);
        endfunction

        function void check_result(t_tracker_result got);
            t_tracker_result want;
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            want = result_q.pop_front();
            if (got.issued_number != want.issued_number) begin
                $display("%0t: issued_number expected %h got %h",
                         $time, want.issued_number, got.issued_number);
                errors++;
            end
            if (got.was_queued != want.was_queued) begin
                $display("%0t: was_queued expected %b got %b",
                         $time, want.was_queued, got.was_queued);
                errors++;
            end
            if (got.confirmed_below != want.confirmed_below) begin
                $display("%0t: confirmed_below expected %h got %h",
                         $time, want.confirmed_below, got.confirmed_below);
                errors++;
            end
            if (got.pad != want.pad) begin
                $display("%0t: pad bits expected %h got %h", $time, want.pad, got.pad);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [31:0] i_s_tdata  = '0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [71:0] o_m_tdata;

    pending_scoreboard sb = new();
    int                results_out = 0;

    pending_work_tracker u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [31:0] completed_value
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)    // [31:0] issued, [32] queued, [64:33] confirmed
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("pending_work_tracker_tb: errors");
        $finish;
    end

    // every fourth run of 50 words goes without idle cycles
    function automatic int pause_cycles(int seq);
        if ((seq / 50) % 4 == 3) return 0;
        return $urandom_range(0, 4);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(t_tracker_result'(o_m_tdata));
            results_out++;
        end
    end

    // result side, with one long hold-off to back the block up
    initial begin
        int  gap;
        bit  held_off;
        held_off = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = pause_cycles(results_out);
            if (!held_off && sb.words_in >= 120) begin
                gap      = HOLD_OFF;
                held_off = 1'b1;
            end
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    task automatic send_word(logic [31:0] value);
        int gap;
        gap = pause_cycles(sb.words_in);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  <= value;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_word(value);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_pending();
        return sb.pending_q[$urandom_range(0, sb.pending_q.size() - 1)];
    endfunction

    initial begin
        int          sel;
        logic [31:0] value;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, head removal, absent values, fill to full,
        // then removals from tail, middle and head of a full ring
        send_word(32'd0);
        send_word(32'hFFFF_FFFF);
        send_word(sb.pending_q[0]);
        send_word(32'h8000_0000);
        repeat (14) send_word(32'd0);
        send_word(32'd1);
        send_word(sb.pending_q[$]);
        send_word(sb.pending_q[sb.pending_q.size() / 2]);
        send_word(32'h7FFF_FFFF);
        send_word(sb.pending_q[0]);
        send_word(32'd0);

        repeat (RANDOM_WORDS) begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                value = pick_pending();
            else if (sel < 70)
                value = 32'd0;
            else if (sel < 85)
                value = $urandom;
            else
                value = pick_pending() + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
            send_word(value);
        end
        i_s_tvalid <= 1'b0;

        while (sb.result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("pending_work_tracker_tb: clean");
        else
            $display("pending_work_tracker_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
